// ===== rtl/core/fexp_pkg.sv =====
// Package for the single-precision exponential unit: constants, pipeline types, float helpers.
`timescale 1ns / 1ps

package fexp_pkg;

    localparam int NUM_STAGES = 16;

    // Stage operations in pipeline order
    localparam int ST_MUL_LOG2E = 1;
    localparam int ST_ADD_HALF  = 2;
    localparam int ST_TO_INT    = 3;
    localparam int ST_MUL_LN2   = 4;
    localparam int ST_SUB_R     = 5;
    localparam int ST_MUL_C5    = 6;
    localparam int ST_ADD_C4    = 7;
    localparam int ST_MUL_R4    = 8;
    localparam int ST_ADD_C3    = 9;
    localparam int ST_MUL_R3    = 10;
    localparam int ST_ADD_C2    = 11;
    localparam int ST_MUL_R2    = 12;
    localparam int ST_ADD_C1    = 13;
    localparam int ST_MUL_SQ    = 14;
    localparam int ST_ADD_P     = 15;
    localparam int ST_SCALE     = 16;

    localparam logic [31:0] F_LOG2E   = 32'h3FB8AA3B;
    localparam logic [31:0] F_LN2     = 32'h3F317218;
    localparam logic [31:0] F_HALF    = 32'h3F000000;
    localparam logic [31:0] F_ONE     = 32'h3F800000;
    localparam logic [31:0] F_C3      = 32'h3E2AAAAB;
    localparam logic [31:0] F_C4      = 32'h3D2AAAAC;
    localparam logic [31:0] F_C5      = 32'h3C088885;
    localparam logic [31:0] F_C6      = 32'h3AB60B6A;
    localparam logic [31:0] F_BIG     = 32'h7F7FC99E;
    localparam logic [31:0] F_QNAN    = 32'h7FC00000;
    localparam logic [30:0] F_LIMIT   = 31'h42B00000;
    localparam logic [30:0] F_INF_MAG = 31'h7F800000;

    typedef struct packed {
        logic              valid;
        logic              spec;
        logic [31:0]       sbits;
        logic signed [8:0] n;
        logic [31:0]       x;
        logic [31:0]       r;
        logic [31:0]       r2;
        logic [31:0]       acc;
    } fexp_pipe_t;

    function automatic logic [5:0] clz50(input logic [49:0] m);
        logic [5:0] lz;
        lz = 6'd50;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) lz = 6'(49 - i);
        end
        return lz;
    endfunction

    // Normalize and round to nearest even; bit 49 of m weighs 2^(e-127).
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e,
                                            input logic [49:0] m);
        logic [5:0]        lz;
        logic [49:0]       mn;
        logic signed [11:0] en;
        logic [11:0]       shw;
        logic [5:0]        sh;
        logic              stk;
        logic [23:0]       mant;
        logic [24:0]       mr;
        logic              rnd;
        logic [7:0]        ef;
        if (m == 50'd0) return {s, 31'd0};
        lz  = clz50(m);
        mn  = m << lz;
        en  = e - $signed({6'd0, lz});
        stk = 1'b0;
        if (en < 12'sd1) begin
            shw = 12'(12'sd1 - en);
            sh  = (shw > 12'd50) ? 6'd50 : shw[5:0];
            stk = |(mn & ~({50{1'b1}} << sh));
            mn  = mn >> sh;
            en  = 12'sd1;
        end
        mant = mn[49:26];
        rnd  = mn[25] & (stk | (|mn[24:0]) | mant[0]);
        mr   = {1'b0, mant} + {24'd0, rnd};
        if (mr[24]) begin
            mant = mr[24:1];
            en   = en + 12'sd1;
        end else begin
            mant = mr[23:0];
        end
        if (en >= 12'sd255) return {s, 8'hFF, 23'd0};
        ef = mant[23] ? en[7:0] : 8'd0;
        return {s, ef, mant[22:0]};
    endfunction

    function automatic logic signed [11:0] fp_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    endfunction

    function automatic logic [23:0] fp_man(input logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [47:0]        prod;
        logic signed [11:0] e;
        prod = 48'(fp_man(a)) * 48'(fp_man(b));
        e    = fp_exp(a) + fp_exp(b) - 12'sd126;
        return fp_pack(a[31] ^ b[31], e, {prod, 2'b00});
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] bg;
        logic [31:0] sm;
        logic [7:0]  d;
        logic [5:0]  sh;
        logic [49:0] big;
        logic [49:0] smf;
        logic [49:0] sma;
        logic [49:0] sum;
        logic        stk;
        if (a[30:0] < b[30:0]) begin
            bg = b;
            sm = a;
        end else begin
            bg = a;
            sm = b;
        end
        d   = 8'(fp_exp(bg) - fp_exp(sm));
        sh  = (d > 8'd50) ? 6'd50 : d[5:0];
        big = {1'b0, fp_man(bg), 25'd0};
        smf = {1'b0, fp_man(sm), 25'd0};
        stk = |(smf & ~({50{1'b1}} << sh));
        sma = (smf >> sh) | {49'd0, stk};
        sum = (bg[31] == sm[31]) ? big + sma : big - sma;
        if (sum == 50'd0) begin
            return {(bg[30:0] == 31'd0) & bg[31] & sm[31], 31'd0};
        end
        return fp_pack(bg[31], fp_exp(bg) + 12'sd1, sum);
    endfunction

    // Truncate toward zero; the argument stays below 128 in magnitude for inputs within the +/-88 limit.
    function automatic logic signed [8:0] fp_to_int(input logic [31:0] q);
        logic [7:0]  sh;
        logic [23:0] sv;
        logic [8:0]  mag;
        if (q[30:23] < 8'd127) return 9'sd0;
        sh  = q[30:23] - 8'd127;
        if (sh > 8'd7) sh = 8'd7;
        sv  = {1'b1, q[22:0]} >> (8'd23 - sh);
        mag = {1'b0, sv[7:0]};
        return q[31] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [31:0] int_to_fp(input logic signed [8:0] n);
        logic [8:0] mag;
        mag = n[8] ? 9'(-n) : 9'(n);
        return fp_pack(n[8], 12'sd134, {mag[7:0], 42'd0});
    endfunction

    function automatic logic [31:0] fp_scale(input logic [31:0] p, input logic signed [8:0] n);
        logic signed [9:0] e;
        if (p[30:0] == 31'd0) return 32'd0;
        e = $signed({2'b00, p[30:23]}) + $signed({n[8], n});
        if (e >= 10'sd255) return p[31] ? {1'b1, F_BIG[30:0]} : F_BIG;
        if (e <= 10'sd0) return 32'd0;
        return {p[31], e[7:0], p[22:0]};
    endfunction

    function automatic fexp_pipe_t fexp_step(input int stage, input fexp_pipe_t p);
        fexp_pipe_t o;
        o = p;
        case (stage)
            ST_MUL_LOG2E: begin
                o.spec  = 1'b1;
                if (p.x[30:23] == 8'hFF && p.x[22:0] != 23'd0) o.sbits = F_QNAN;
                else if (p.x[30:0] > F_LIMIT && !p.x[31])     o.sbits = F_BIG;
                else if (p.x[30:0] > F_LIMIT)                 o.sbits = 32'd0;
                else                                          o.spec  = 1'b0;
                o.acc = fp_mul(p.x, F_LOG2E);
            end
            ST_ADD_HALF:
                o.acc = fp_add(p.acc, {p.acc[31] && p.acc[30:0] != 31'd0, F_HALF[30:0]});
            ST_TO_INT: begin
                o.n   = fp_to_int(p.acc);
                o.acc = int_to_fp(fp_to_int(p.acc));
            end
            ST_MUL_LN2: o.acc = fp_mul(p.acc, F_LN2);
            ST_SUB_R:   o.r   = fp_add(p.x, {~p.acc[31], p.acc[30:0]});
            ST_MUL_C5: begin
                o.r2  = fp_mul(p.r, p.r);
                o.acc = fp_mul(p.r, F_C6);
            end
            ST_ADD_C4:  o.acc = fp_add(F_C5, p.acc);
            ST_MUL_R4:  o.acc = fp_mul(p.r, p.acc);
            ST_ADD_C3:  o.acc = fp_add(F_C4, p.acc);
            ST_MUL_R3:  o.acc = fp_mul(p.r, p.acc);
            ST_ADD_C2:  o.acc = fp_add(F_C3, p.acc);
            ST_MUL_R2:  o.acc = fp_mul(p.r, p.acc);
            ST_ADD_C1:  o.acc = fp_add(F_HALF, p.acc);
            ST_MUL_SQ: begin
                o.acc = fp_mul(p.r2, p.acc);
                o.r2  = fp_add(F_ONE, p.r);
            end
            ST_ADD_P:   o.acc = fp_add(p.r2, p.acc);
            ST_SCALE:   o.acc = p.spec ? p.sbits : fp_scale(p.acc, p.n);
            default:    o = p;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/core/fexp_stage.sv =====
// One register stage of the exponential pipeline: fexp_step logic, then a register.
`timescale 1ns / 1ps

module fexp_stage
    import fexp_pkg::*;
#(
    parameter int STAGE = ST_MUL_LOG2E
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  fexp_pipe_t prev,
    output fexp_pipe_t cur
);

    logic       valid_reg;
    fexp_pipe_t cur_reg;
    fexp_pipe_t cur_next;

    always_comb
    begin
        cur_next = fexp_step(STAGE, prev);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prev.valid;
        end
    end

    // Payload carries no reset; the valid bit qualifies it.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_comb
    begin
        cur       = cur_reg;
        cur.valid = valid_reg;
    end

endmodule

// ===== rtl/core/float_exponential_unit.sv =====
// Top level of the single-precision exponential unit.
`timescale 1ns / 1ps

// Computes e^x on IEEE single-precision bit patterns, one argument per clock.
// busy never rises, so an argument may be started in every cycle. Each result
// appears on result_bits with done high for exactly one cycle, once the start
// transfer has passed an input register and sixteen stages, each holding one or
// two float multiplies or adds (or the integer conversion, or the final exponent
// scaling). Results come out in start order and the receiver cannot stall them.
// NaN gives 0x7FC00000, x above 88 gives 0x7F7FC99E, x below -88 gives +0.

module float_exponential_unit
    import fexp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] x_bits,
    output logic        done,
    output logic [31:0] result_bits
);

    logic       in_valid_reg;
    logic [31:0] x_reg;
    fexp_pipe_t pipe [0:NUM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_bits;
    end

    assign pipe[0] = '{valid: in_valid_reg, x: x_reg, default: '0};

    for (genvar i = 1; i <= NUM_STAGES; i++)
    begin : g_stage
        fexp_stage #(
            .STAGE (i)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .prev  (pipe[i-1]),
            .cur   (pipe[i])
        );
    end

    assign busy        = 1'b0;
    assign done        = pipe[NUM_STAGES].valid;
    assign result_bits = pipe[NUM_STAGES].acc;

endmodule

// ===== rtl/core/fexp_checker.sv =====
// Port-level checker for the exponential unit, bound to the top level.
`timescale 1ns / 1ps

module fexp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] x_bits,
    input logic        done,
    input logic [31:0] result_bits
);

    localparam int LATENCY = 17;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transfer produced no result");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transfer");

    a_nan_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && x_bits[30:23] == 8'hFF && x_bits[22:0] != 23'd0)
            |-> ##LATENCY (result_bits == 32'h7FC00000))
        else $error("NaN argument gave wrong result");

    a_big_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !x_bits[31] && x_bits[30:0] > 31'h42B00000
            && x_bits[30:0] <= 31'h7F800000)
            |-> ##LATENCY (result_bits == 32'h7F7FC99E))
        else $error("large argument did not saturate");

endmodule

bind float_exponential_unit fexp_checker u_fexp_checker (.*);
